/* rtl/mfr_pkg.sv */
package mfr_pkg;

    localparam int CMD_LEN = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_CODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUCCESSIVE_CODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_TYPE        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_ADDR        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_CAPACITY   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CODE  = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_SEQUENCE  = 3'd3;
    localparam logic [2:0] ST_DEST_FULL = 3'd4;
    localparam logic [2:0] ST_IGNORE    = 3'd7;

    localparam logic MODE_INITIAL = 1'b0;

    typedef struct packed {
        logic [63:0] initial_code;
        logic [63:0] successive_code;
        logic        has_type;
        logic        has_addr;
        logic [31:0] dest_capacity;
    } cfg_t;

    typedef struct packed {
        logic        write_valid;
        logic [31:0] write_address;
        logic [7:0]  write_byte;
        logic        packet_done;
        logic [2:0]  status;
        logic [31:0] message_type;
        logic [31:0] message_address;
        logic [31:0] bytes_remaining;
    } result_t;

    function automatic logic [7:0] code_byte(input logic [63:0] code, input logic [7:0] pos);
        logic [7:0] sel;
        sel = '0;
        for (int i = 0; i < CMD_LEN; i++)
        begin
            if (pos == 8'(i))
            begin
                sel = code[8*(CMD_LEN-1-i) +: 8];
            end
        end
        return sel;
    endfunction

endpackage

/* rtl/mfr_cfg.sv */
module mfr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output mfr_pkg::cfg_t                       cfg
);
    import mfr_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INITIAL_CODE:    cfg_reg.initial_code <= cfg_data;
                CFG_SUCCESSIVE_CODE: cfg_reg.successive_code <= cfg_data;
                CFG_HAS_TYPE:        cfg_reg.has_type <= cfg_data[0];
                CFG_HAS_ADDR:        cfg_reg.has_addr <= cfg_data[0];
                CFG_DEST_CAPACITY:   cfg_reg.dest_capacity <= cfg_data[31:0];
                default:             ;
            endcase
        end
    end

endmodule

/* rtl/mfr_frame.sv */
module mfr_frame (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             mode_in,
    input  logic [7:0]       byte_in,
    input  logic [7:0]       length_in,
    input  mfr_pkg::cfg_t    cfg,
    output mfr_pkg::result_t res
);
    import mfr_pkg::*;

    localparam logic [8:0] CODE_END = 9'(CMD_LEN);
    localparam logic [8:0] SEQ_END  = 9'(CMD_LEN + 4);

    logic [7:0]  byte_position_reg, byte_position_next;
    logic [31:0] expected_sequence_reg, expected_sequence_next;
    logic [31:0] data_remaining_reg, data_remaining_next;
    logic [31:0] write_pointer_reg, write_pointer_next;
    logic [31:0] stored_type_reg, stored_type_next;
    logic [31:0] stored_address_reg, stored_address_next;
    logic [31:0] word_shift_reg, word_shift_next;
    logic [2:0]  packet_error_reg, packet_error_next;
    logic [7:0]  copy_limit_reg, copy_limit_next;

    always_comb
    begin
        logic [8:0]  p1;
        logic        first;
        logic        last;
        logic [8:0]  tend;
        logic [8:0]  aend;
        logic [8:0]  lend;
        logic [7:0]  cpy;
        logic [32:0] fit_sum;

        p1 = {1'b0, byte_position_reg} + 9'd1;
        first = (byte_position_reg == 8'd0);
        last = (p1 >= {1'b0, length_in});
        tend = CODE_END + (cfg.has_type ? 9'd4 : 9'd0);
        aend = tend + (cfg.has_addr ? 9'd4 : 9'd0);
        lend = aend + 9'd4;
        cpy = '0;
        fit_sum = '0;

        expected_sequence_next = expected_sequence_reg;
        data_remaining_next = data_remaining_reg;
        write_pointer_next = write_pointer_reg;
        stored_type_next = stored_type_reg;
        stored_address_next = stored_address_reg;
        packet_error_next = first ? ST_OK : packet_error_reg;
        copy_limit_next = first ? 8'd0 : copy_limit_reg;
        word_shift_next = {(first ? 24'd0 : word_shift_reg[23:0]), byte_in};

        res = '0;

        if (mode_in == MODE_INITIAL)
        begin
            if (first)
            begin
                expected_sequence_next = '0;
                write_pointer_next = '0;
            end
            if (packet_error_next == ST_OK)
            begin
                if ({1'b0, byte_position_reg} < CODE_END)
                begin
                    if (byte_in != code_byte(cfg.initial_code, byte_position_reg))
                    begin
                        packet_error_next = ST_BAD_CODE;
                    end
                end
                else if (p1 == tend && cfg.has_type)
                begin
                    stored_type_next = word_shift_next;
                end
                else if (p1 == aend && cfg.has_addr)
                begin
                    stored_address_next = word_shift_next;
                end
                else if (p1 == lend)
                begin
                    data_remaining_next = word_shift_next;
                end
                if (last && packet_error_next == ST_OK && p1 < lend)
                begin
                    packet_error_next = ST_SHORT;
                end
            end
        end
        else
        begin
            if (first && data_remaining_reg == 32'd0)
            begin
                packet_error_next = ST_IGNORE;
            end
            if (packet_error_next == ST_OK)
            begin
                if ({1'b0, byte_position_reg} < CODE_END)
                begin
                    if (byte_in != code_byte(cfg.successive_code, byte_position_reg))
                    begin
                        packet_error_next = ST_BAD_CODE;
                    end
                end
                else if (p1 == SEQ_END)
                begin
                    if (word_shift_next == expected_sequence_reg)
                    begin
                        cpy = ({1'b0, length_in} > p1) ? (length_in - p1[7:0]) : 8'd0;
                        expected_sequence_next = expected_sequence_reg + 32'd1;
                        if ({24'd0, cpy} > data_remaining_reg)
                        begin
                            cpy = data_remaining_reg[7:0];
                        end
                        fit_sum = {1'b0, write_pointer_reg} + {25'd0, cpy};
                        if (fit_sum <= {1'b0, cfg.dest_capacity})
                        begin
                            copy_limit_next = cpy;
                        end
                        else
                        begin
                            packet_error_next = ST_DEST_FULL;
                            copy_limit_next = '0;
                        end
                    end
                    else
                    begin
                        packet_error_next = ST_SEQUENCE;
                    end
                end
                else if ({1'b0, byte_position_reg} >= SEQ_END
                         && (byte_position_reg - SEQ_END[7:0]) < copy_limit_next)
                begin
                    res.write_valid = 1'b1;
                    res.write_address = write_pointer_reg;
                    res.write_byte = byte_in;
                    write_pointer_next = write_pointer_reg + 32'd1;
                    data_remaining_next = data_remaining_reg - 32'd1;
                end
                if (last && packet_error_next == ST_OK && p1 < SEQ_END)
                begin
                    packet_error_next = ST_SHORT;
                end
            end
        end

        if (last)
        begin
            res.packet_done = 1'b1;
            res.status = (packet_error_next == ST_IGNORE) ? ST_OK : packet_error_next;
            byte_position_next = '0;
        end
        else
        begin
            byte_position_next = p1[7:0];
        end

        res.message_type = stored_type_next;
        res.message_address = stored_address_next;
        res.bytes_remaining = data_remaining_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            expected_sequence_reg <= '0;
            data_remaining_reg <= '0;
            write_pointer_reg <= '0;
            stored_type_reg <= '0;
            stored_address_reg <= '0;
            word_shift_reg <= '0;
            packet_error_reg <= ST_OK;
            copy_limit_reg <= '0;
        end
        else if (step)
        begin
            byte_position_reg <= byte_position_next;
            expected_sequence_reg <= expected_sequence_next;
            data_remaining_reg <= data_remaining_next;
            write_pointer_reg <= write_pointer_next;
            stored_type_reg <= stored_type_next;
            stored_address_reg <= stored_address_next;
            word_shift_reg <= word_shift_next;
            packet_error_reg <= packet_error_next;
            copy_limit_reg <= copy_limit_next;
        end
    end

endmodule

/* rtl/multipacket_frame_receiver_core.sv */
// a byte passes the input register, then its result is held in the result register
// throughput: one byte per cycle unless stalled; one frame state update per byte
// the input register and result register form a two-stage pipeline with stall
// reset: asynchronous, active low; clears frame state, config registers and valids
module multipacket_frame_receiver_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [7:0]                          packet_byte,
    input  logic [7:0]                          packet_length,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                write_valid,
    output logic [31:0]                         write_address,
    output logic [7:0]                          write_byte,
    output logic                                packet_done,
    output logic [2:0]                          status,
    output logic [31:0]                         message_type,
    output logic [31:0]                         message_address,
    output logic [31:0]                         bytes_remaining,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mfr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mfr_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t res_reg;

    logic       in_valid_reg;
    logic       mode_reg;
    logic [7:0] byte_reg;
    logic [7:0] length_reg;
    logic       out_valid_reg;
    logic       out_block;
    logic       step;

    assign out_block = out_valid_reg && out_stall;
    assign step = in_valid_reg && !out_block;
    assign in_stall = in_valid_reg && out_block;

    mfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mfr_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .mode_in   (mode_reg),
        .byte_in   (byte_reg),
        .length_in (length_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg <= mode;
            byte_reg <= packet_byte;
            length_reg <= packet_length;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_block)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign write_valid = res_reg.write_valid;
    assign write_address = res_reg.write_address;
    assign write_byte = res_reg.write_byte;
    assign packet_done = res_reg.packet_done;
    assign status = res_reg.status;
    assign message_type = res_reg.message_type;
    assign message_address = res_reg.message_address;
    assign bytes_remaining = res_reg.bytes_remaining;

endmodule
